FILE: hdl/lcc_pkg.sv
// shared constants, beat types and pipeline records for the line/circle clipper
package lcc_pkg;

  localparam int CoordBits = 12;
  localparam int TFracBits = 16;

  localparam int DW     = CoordBits + 1;
  localparam int AW     = 2 * CoordBits + 2;
  localparam int R2W    = 2 * CoordBits;
  localparam int HW     = 2 * CoordBits + 4;
  localparam int CcW    = 2 * (HW - 1);
  localparam int RadW   = AW + R2W;
  localparam int RootW  = RadW / 2;
  localparam int RemW   = RootW + 3;
  localparam int NumW   = HW + 1;
  localparam int NW     = NumW + TFracBits + 2;
  localparam int DivW   = NW - 1;
  localparam int QW     = TFracBits + CoordBits + 3;
  localparam int DvW    = AW + 1;
  localparam int DRemW  = DvW + 1;
  localparam int TW     = QW + 1;
  localparam int LW     = TFracBits + CoordBits + 3;
  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindWhole = 2'd1;
  localparam logic [1:0] KindClip  = 2'd2;

  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegRadius  = 2'd2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DW-1:0] delta_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_beat_t;

  typedef struct packed {
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } out_beat_t;

  typedef struct packed {
    coord_t                 x0;
    coord_t                 y0;
    coord_t                 x1;
    coord_t                 y1;
    delta_t                 dx;
    delta_t                 dy;
    logic [1:0]             kind;
    logic signed [HW-1:0]   h;
    logic [AW-1:0]          a;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic             neg;
    logic [DRemW-1:0] rem;
    logic [QW-1:0]    dvd;
    logic [QW-1:0]    quo;
  } div_lane_t;

  typedef struct packed {
    side_t          side;
    logic [DvW-1:0] dsr;
    div_lane_t      lo;
    div_lane_t      hi;
  } div_t;

  function automatic delta_t sx(coord_t c);
    return {c[CoordBits-1], c};
  endfunction

endpackage

FILE: hdl/lcc_front.sv
// front end: deltas, squares, inside tests, discriminant and case selection
module lcc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  lcc_pkg::in_beat_t             data_i,
  input  lcc_pkg::coord_t               cx_i,
  input  lcc_pkg::coord_t               cy_i,
  input  logic [lcc_pkg::CoordBits-1:0] r_i,
  output logic                          valid_o,
  output lcc_pkg::sqrt_t                data_o
);
  import lcc_pkg::*;

  // stage 0
  logic v0_q;
  side_t s0_q;
  delta_t fx_q, fy_q, gx_q, gy_q;
  logic [CoordBits-1:0] r0_q;

  // stage 1
  logic v1_q;
  side_t s1_q;
  logic signed [HW-1:0] cr_q;
  logic in0_q, in1_q, rz_q;
  logic [R2W-1:0] r2_q;

  // stage 2
  logic v2_q;
  side_t s2_q;
  logic [RadW-1:0] ar_q;
  logic [CcW-1:0] cc_q;

  // stage 3
  logic v3_q;
  sqrt_t s3_q;

  side_t s0_d, s1_d, s2_d;
  sqrt_t s3_d;
  logic signed [HW-1:0] pxx, pyy, pfx, pfy, pgx, pgy, phx, phy, pcx, pcy;
  logic signed [HW-1:0] a_sum, d0, d1;
  logic signed [HW-1:0] cr_abs;
  logic [R2W-1:0] r2;
  logic [HW-2:0] crm;
  logic [1:0] kind2;
  logic [1:0] kind3;

  always_comb begin
    s0_d      = '0;
    s0_d.x0   = data_i.start_x;
    s0_d.y0   = data_i.start_y;
    s0_d.x1   = data_i.end_x;
    s0_d.y1   = data_i.end_y;
    s0_d.dx   = sx(data_i.end_x) - sx(data_i.start_x);
    s0_d.dy   = sx(data_i.end_y) - sx(data_i.start_y);
    s0_d.kind = KindNone;
  end

  always_comb begin
    pxx   = s0_q.dx * s0_q.dx;
    pyy   = s0_q.dy * s0_q.dy;
    pfx   = fx_q * fx_q;
    pfy   = fy_q * fy_q;
    pgx   = gx_q * gx_q;
    pgy   = gy_q * gy_q;
    phx   = fx_q * s0_q.dx;
    phy   = fy_q * s0_q.dy;
    pcx   = fx_q * s0_q.dy;
    pcy   = fy_q * s0_q.dx;
    a_sum = pxx + pyy;
    d0    = pfx + pfy;
    d1    = pgx + pgy;
    r2    = r0_q * r0_q;
  end

  always_comb begin
    cr_abs = cr_q[HW-1] ? -cr_q : cr_q;
    crm    = cr_abs[HW-2:0];
    if (rz_q) begin
      kind2 = KindNone;
    end else if (s1_q.a == '0) begin
      kind2 = in0_q ? KindWhole : KindNone;
    end else if (in0_q && in1_q) begin
      kind2 = KindWhole;
    end else begin
      kind2 = KindClip;
    end
  end

  always_comb begin
    kind3 = s2_q.kind;
    if (s2_q.kind == KindClip && cc_q > {{(CcW-RadW){1'b0}}, ar_q}) begin
      kind3 = KindNone;
    end
  end

  always_comb begin
    s1_d           = s0_q;
    s1_d.a         = a_sum[AW-1:0];
    s1_d.h         = phx + phy;
    s2_d           = s1_q;
    s2_d.kind      = kind2;
    s3_d.side      = s2_q;
    s3_d.side.kind = kind3;
    s3_d.rad       = ar_q - cc_q[RadW-1:0];
    s3_d.rem       = '0;
    s3_d.root      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s0_q <= s0_d;
      fx_q <= sx(data_i.start_x) - sx(cx_i);
      fy_q <= sx(data_i.start_y) - sx(cy_i);
      gx_q <= sx(data_i.end_x) - sx(cx_i);
      gy_q <= sx(data_i.end_y) - sx(cy_i);
      r0_q <= r_i;

      s1_q   <= s1_d;
      cr_q   <= pcx - pcy;
      in0_q  <= unsigned'(d0) <= {{(HW-R2W){1'b0}}, r2};
      in1_q  <= unsigned'(d1) <= {{(HW-R2W){1'b0}}, r2};
      rz_q   <= r0_q == '0;
      r2_q   <= r2;

      s2_q      <= s2_d;
      ar_q      <= s1_q.a * r2_q;
      cc_q      <= crm * crm;

      s3_q      <= s3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = s3_q;

endmodule

FILE: hdl/lcc_sqrt_cell.sv
// one root bit of the square root chain
module lcc_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  lcc_pkg::sqrt_t data_i,
  output logic           valid_o,
  output lcc_pkg::sqrt_t data_o
);
  import lcc_pkg::*;

  logic valid_q;
  sqrt_t data_q, data_d;
  logic [RemW-1:0] rem_sh, trial;

  always_comb begin
    rem_sh      = {data_i.rem[RemW-3:0], data_i.rad[RadW-1 -: 2]};
    trial       = {{(RemW-RootW-2){1'b0}}, data_i.root, 2'b01};
    data_d      = data_i;
    data_d.rad  = {data_i.rad[RadW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      data_d.rem  = rem_sh - trial;
      data_d.root = {data_i.root[RootW-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh;
      data_d.root = {data_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/lcc_div_cell.sv
// one quotient bit of the two divider lanes
module lcc_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  lcc_pkg::div_t data_i,
  output logic          valid_o,
  output lcc_pkg::div_t data_o
);
  import lcc_pkg::*;

  logic valid_q;
  div_t data_q, data_d;

  function automatic div_lane_t step(div_lane_t l, logic [DvW-1:0] dsr);
    logic [DRemW-1:0] rs;
    div_lane_t o;
    rs    = {l.rem[DRemW-2:0], l.dvd[QW-1]};
    o     = l;
    o.dvd = {l.dvd[QW-2:0], 1'b0};
    if (rs >= {1'b0, dsr}) begin
      o.rem = rs - {1'b0, dsr};
      o.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = rs;
      o.quo = {l.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    data_d    = data_i;
    data_d.lo = step(data_i.lo, data_i.dsr);
    data_d.hi = step(data_i.hi, data_i.dsr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/lcc_tail.sv
// back end: clamp of the crossing parameters, pixel interpolation, output register
module lcc_tail (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  lcc_pkg::div_t      data_i,
  output logic               valid_o,
  output lcc_pkg::out_beat_t data_o
);
  import lcc_pkg::*;

  localparam logic signed [TW-1:0] OneT = TW'(1) <<< TFracBits;

  logic e1_v_q, e2_v_q;
  side_t e1_side_q;
  logic e1_vis_q;
  logic [TFracBits:0] ts_q, te_q;
  out_beat_t out_q, out_d;

  logic signed [TW-1:0] t1, t2, ts, te;
  logic vis;

  function automatic coord_t lerp(coord_t p0, delta_t d, logic [TFracBits:0] t);
    logic signed [LW-1:0] p;
    logic signed [LW-1:0] pr;
    p  = $signed({1'b0, t}) * d;
    pr = p + (LW'(1) <<< (TFracBits - 1));
    return p0 + pr[TFracBits +: CoordBits];
  endfunction

  always_comb begin
    t1  = data_i.lo.neg ? ~$signed({1'b0, data_i.lo.quo}) : $signed({1'b0, data_i.lo.quo});
    t2  = data_i.hi.neg ? ~$signed({1'b0, data_i.hi.quo}) : $signed({1'b0, data_i.hi.quo});
    ts  = (t1 < 0) ? '0 : t1;
    te  = (t2 > OneT) ? OneT : t2;
    vis = (data_i.side.kind == KindWhole) || (data_i.side.kind == KindClip && ts <= te);
  end

  always_comb begin
    out_d = '0;
    if (e1_vis_q) begin
      out_d.visible = 1'b1;
      if (e1_side_q.kind == KindWhole) begin
        out_d.clip_start_x = e1_side_q.x0;
        out_d.clip_start_y = e1_side_q.y0;
        out_d.clip_end_x   = e1_side_q.x1;
        out_d.clip_end_y   = e1_side_q.y1;
      end else begin
        out_d.clip_start_x = lerp(e1_side_q.x0, e1_side_q.dx, ts_q);
        out_d.clip_start_y = lerp(e1_side_q.y0, e1_side_q.dy, ts_q);
        out_d.clip_end_x   = lerp(e1_side_q.x0, e1_side_q.dx, te_q);
        out_d.clip_end_y   = lerp(e1_side_q.y0, e1_side_q.dy, te_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
    end else if (adv_i) begin
      e1_v_q <= valid_i;
      e2_v_q <= e1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e1_side_q <= data_i.side;
      e1_vis_q  <= vis;
      ts_q      <= ts[TFracBits:0];
      te_q      <= te[TFracBits:0];
      out_q     <= out_d;
    end
  end

  assign valid_o = e2_v_q;
  assign data_o  = out_q;

endmodule

FILE: hdl/line_circle_clip_unit.sv
// top level of the line segment / circle clipper
// Clips one segment per beat against the circle held in the center_x, center_y and radius
// registers (APB, byte addresses 0x0, 0x4, 0x8). A new segment is taken every clock cycle
// while the output is not stalled; each one passes the front end, the chain of one-bit square
// root cells, the divider setup register, the chain of one-bit divider cells and the output
// stage. When the output is stalled the whole pipeline holds and in_ready_o drops.
module line_circle_clip_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lcc_pkg::in_beat_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lcc_pkg::out_beat_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcc_pkg::PaddrW-1:0]  paddr,
  input  logic [lcc_pkg::PdataW-1:0]  pwdata,
  output logic [lcc_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);
  import lcc_pkg::*;

  coord_t cx_q, cy_q;
  logic [CoordBits-1:0] r_q;
  logic adv;

  sqrt_t sq [RootW+1];
  logic  sq_v [RootW+1];
  div_t  dv [QW+1];
  logic  dv_v [QW+1];

  div_t nm_d;
  logic signed [NumW-1:0] hx, sxv, num_lo, num_hi;
  logic signed [NW-1:0] n_lo, n_hi, a_ext;
  logic [DivW-1:0] m_lo, m_hi;

  assign pready = 1'b1;
  assign adv    = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      r_q  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegCenterX: cx_q <= pwdata[CoordBits-1:0];
        RegCenterY: cy_q <= pwdata[CoordBits-1:0];
        RegRadius:  r_q  <= pwdata[CoordBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegCenterX: prdata = {{(PdataW-CoordBits){1'b0}}, cx_q};
      RegCenterY: prdata = {{(PdataW-CoordBits){1'b0}}, cy_q};
      RegRadius:  prdata = {{(PdataW-CoordBits){1'b0}}, r_q};
      default:    prdata = '0;
    endcase
  end

  lcc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cx_i    (cx_q),
    .cy_i    (cy_q),
    .r_i     (r_q),
    .valid_o (sq_v[0]),
    .data_o  (sq[0])
  );

  for (genvar i = 0; i < RootW; i++) begin : g_sqrt
    lcc_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (sq_v[i]),
      .data_i  (sq[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq[i+1])
    );
  end

  // numerators of the two crossing parameters and divider setup
  always_comb begin
    hx     = NumW'(sq[RootW].side.h);
    sxv    = $signed({{(NumW-RootW){1'b0}}, sq[RootW].root});
    num_lo = -hx - sxv;
    num_hi = -hx + sxv;
    a_ext  = $signed({{(NW-AW){1'b0}}, sq[RootW].side.a});
    n_lo   = (NW'(num_lo) <<< (TFracBits + 1)) + a_ext;
    n_hi   = (NW'(num_hi) <<< (TFracBits + 1)) + a_ext;
    m_lo   = n_lo[NW-1] ? ~n_lo[DivW-1:0] : n_lo[DivW-1:0];
    m_hi   = n_hi[NW-1] ? ~n_hi[DivW-1:0] : n_hi[DivW-1:0];

    nm_d.side   = sq[RootW].side;
    nm_d.dsr    = {sq[RootW].side.a, 1'b0};
    nm_d.lo.neg = n_lo[NW-1];
    nm_d.lo.rem = {{(DRemW-(DivW-QW)){1'b0}}, m_lo[DivW-1:QW]};
    nm_d.lo.dvd = m_lo[QW-1:0];
    nm_d.lo.quo = '0;
    nm_d.hi.neg = n_hi[NW-1];
    nm_d.hi.rem = {{(DRemW-(DivW-QW)){1'b0}}, m_hi[DivW-1:QW]};
    nm_d.hi.dvd = m_hi[QW-1:0];
    nm_d.hi.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv[0] <= nm_d;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    lcc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv_v[j]),
      .data_i  (dv[j]),
      .valid_o (dv_v[j+1]),
      .data_o  (dv[j+1])
    );
  end

  lcc_tail u_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dv_v[QW]),
    .data_i  (dv[QW]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

FILE: tb/sv/tb_line_circle_clip_unit.sv
// testbench for the line segment / circle clipper: directed and random segments, apb config
module tb_line_circle_clip_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lcc_pkg::*;

  localparam int PipeLatency = 63;
  localparam longint CycleLimit = 2000000;
  localparam int OneT = 1 << TFracBits;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_beat_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic pready;

  line_circle_clip_unit i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  coord_t circ_cx = '0;
  coord_t circ_cy = '0;
  logic [CoordBits-1:0] circ_r = '0;
  out_beat_t clip_q[$];
  int errors = 0;
  longint cycles = 0;
  int rx_hold = 0;
  int rx_mode = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint isqrt(longint v);
    longint res, c;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      c = res | (longint'(1) << b);
      if (c * c <= v) res = c;
    end
    return res;
  endfunction

  function automatic out_beat_t clip_segment(in_beat_t s);
    out_beat_t o;
    longint x0, y0, x1, y1, cx, cy, r2, dx, dy, fx, fy, gx, gy, a, h, cr, disc, sq;
    longint t1, t2, ts, te;
    bit in0, in1;
    x0 = s.start_x; y0 = s.start_y; x1 = s.end_x; y1 = s.end_y;
    cx = circ_cx; cy = circ_cy;
    r2 = longint'(circ_r) * longint'(circ_r);
    dx = x1 - x0; dy = y1 - y0;
    fx = x0 - cx; fy = y0 - cy; gx = x1 - cx; gy = y1 - cy;
    a = dx * dx + dy * dy;
    in0 = fx * fx + fy * fy <= r2;
    in1 = gx * gx + gy * gy <= r2;
    o = '0;
    if (circ_r == 0) begin
    end else if (a == 0) begin
      if (in0) o = '{1'b1, s.start_x, s.start_y, s.start_x, s.start_y};
    end else if (in0 && in1) begin
      o = '{1'b1, s.start_x, s.start_y, s.end_x, s.end_y};
    end else begin
      h = fx * dx + fy * dy;
      cr = fx * dy - fy * dx;
      disc = a * r2 - cr * cr;
      if (disc >= 0) begin
        sq = isqrt(disc);
        t1 = fdiv((-h - sq) * 2 * OneT + a, 2 * a);
        t2 = fdiv((-h + sq) * 2 * OneT + a, 2 * a);
        ts = t1 < 0 ? 0 : t1;
        te = t2 > OneT ? OneT : t2;
        if (ts <= te) begin
          o.visible = 1'b1;
          o.clip_start_x = coord_t'(x0 + fdiv(ts * dx + OneT / 2, OneT));
          o.clip_start_y = coord_t'(y0 + fdiv(ts * dy + OneT / 2, OneT));
          o.clip_end_x = coord_t'(x0 + fdiv(te * dx + OneT / 2, OneT));
          o.clip_end_y = coord_t'(y0 + fdiv(te * dy + OneT / 2, OneT));
        end
      end
    end
    return o;
  endfunction

  task automatic apb_write(logic [1:0] idx, logic [CoordBits-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= PaddrW'(idx) << 2; pwdata <= PdataW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegCenterX: circ_cx = val;
      RegCenterY: circ_cy = val;
      RegRadius:  circ_r = val;
      default: ;
    endcase
  endtask

  task automatic set_circle(int cx, int cy, int r);
    in_valid_i <= 1'b0;
    wait (clip_q.size() == 0);
    repeat (PipeLatency + 4) @(posedge clk_i);
    apb_write(RegCenterX, cx[CoordBits-1:0]);
    apb_write(RegCenterY, cy[CoordBits-1:0]);
    apb_write(RegRadius, r[CoordBits-1:0]);
  endtask

  // called at a falling edge; valid stays high after the beat so beats can follow back to back
  task automatic send_segment(int x0, int y0, int x1, int y1, bit gaps = 1);
    in_beat_t s;
    s = '{coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1)};
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
        @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    clip_q.push_back(clip_segment(s));
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic int rnd_coord();
    return $signed($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int near(int c, int r);
    int v;
    v = c + $signed($urandom_range(0, 2 * r + 8)) - r - 4;
    return v > 2047 ? 2047 : (v < -2048 ? -2048 : v);
  endfunction

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else if (rx_mode == 0) begin
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      rx_hold <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (clip_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = clip_q.pop_front();
        if (out_data_o.visible !== e.visible) begin
          $error("visible exp %0d got %0d", e.visible, out_data_o.visible); errors++;
        end
        if (out_data_o.clip_start_x !== e.clip_start_x) begin
          $error("clip_start_x exp %0d got %0d", e.clip_start_x, out_data_o.clip_start_x);
          errors++;
        end
        if (out_data_o.clip_start_y !== e.clip_start_y) begin
          $error("clip_start_y exp %0d got %0d", e.clip_start_y, out_data_o.clip_start_y);
          errors++;
        end
        if (out_data_o.clip_end_x !== e.clip_end_x) begin
          $error("clip_end_x exp %0d got %0d", e.clip_end_x, out_data_o.clip_end_x);
          errors++;
        end
        if (out_data_o.clip_end_y !== e.clip_end_y) begin
          $error("clip_end_y exp %0d got %0d", e.clip_end_y, out_data_o.clip_end_y);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_radius();
    send_segment(-10, 0, 10, 0);
    send_segment(0, 0, 0, 0);
  endtask

  task automatic test_directed();
    set_circle(0, 0, 100);
    send_segment(0, 0, 0, 0);
    send_segment(200, 0, 200, 0);
    send_segment(-50, 10, 50, -10);
    send_segment(-200, 0, 200, 0);
    send_segment(-200, 100, 200, 100);
    send_segment(-200, 101, 200, 101);
    send_segment(-200, 0, -150, 0);
    send_segment(0, 0, 300, 0);
    send_segment(-2048, -2048, 2047, 2047);
    send_segment(2047, -2048, -2048, 2047);
    send_segment(100, 0, 300, 0);
    set_circle(-2048, -2048, 4095);
    send_segment(2047, 2047, -2048, -2048);
    send_segment(2047, 2047, 2047, 2047);
    send_segment(-2048, 2047, 2047, -2048);
    set_circle(2047, 2047, 1);
    send_segment(2046, 2047, 2047, 2046);
    send_segment(2045, 2048 - 1, 2047, 2045);
    set_circle(5, -7, 0);
    send_segment(5, -7, 6, -7);
  endtask

  task automatic run_random(int n, bit full_range);
    int cx, cy, r;
    cx = rnd_coord(); cy = rnd_coord();
    r = full_range ? $urandom_range(0, 4095) : $urandom_range(1, 300);
    set_circle(cx, cy, r);
    for (int i = 0; i < n; i++) begin
      if (full_range || $urandom_range(0, 4) == 0)
        send_segment(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      else
        send_segment(near(cx, r), near(cy, r), near(cx, 2 * r), near(cy, 2 * r));
    end
  endtask

  task automatic test_random();
    rx_mode = 1;
    for (int p = 0; p < 12; p++) run_random(130, p % 4 == 3);
  endtask

  task automatic test_backpressure();
    int n;
    set_circle(0, 0, 500);
    @(posedge clk_i);
    rx_hold = 400;
    @(negedge clk_i);
    n = 0;
    while (n < 150) begin
      send_segment(near(0, 500), near(0, 500), near(0, 900), near(0, 900), 0);
      n++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_radius();
    test_directed();
    test_random();
    test_backpressure();
    in_valid_i <= 1'b0;
    wait (clip_q.size() == 0);
    repeat (PipeLatency + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lcc_pkg.sv
hdl/lcc_front.sv
hdl/lcc_sqrt_cell.sv
hdl/lcc_div_cell.sv
hdl/lcc_tail.sv
hdl/line_circle_clip_unit.sv
tb/sv/tb_line_circle_clip_unit.sv
